// ===== rtl/core/msfd_pkg.sv =====
package msfd_pkg;

    // Number of items in one non-overlapping accumulation window (2 to 16)
    localparam int WINDOW_LENGTH = 10;
    localparam int POS_W         = (WINDOW_LENGTH > 2) ? $clog2(WINDOW_LENGTH) : 1;

    localparam int NUM_SENSORS  = 4;
    localparam int SENSOR_IDX_W = 2;
    localparam int SAMPLE_W     = 10;
    localparam int SUM_W        = 12;   // cross-sensor sum
    localparam int SUMSQ_W      = 22;   // sum of four squared samples
    localparam int SPREAD_W     = 22;   // 4*sumsq - sum^2
    localparam int WSUM_W       = 14;   // per-sensor window sum
    localparam int VTHR_W       = 19;
    localparam int DTHR_W       = 10;
    localparam int DIST_W       = 17;   // scaled distances and their limit

    localparam logic [VTHR_W-1:0] VTHR_RESET = VTHR_W'(40000);
    localparam logic [DTHR_W-1:0] DTHR_RESET = DTHR_W'(150);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VTHR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VAR_THR  = 1'b0,
        CFG_DIST_THR = 1'b1
    } cfg_reg_t;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;

    typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sample_arr_t;
    typedef logic [NUM_SENSORS-1:0][WSUM_W-1:0]   wsum_arr_t;

    // Window and fault-test outcome for one item
    typedef struct packed {
        logic                    window_end;
        logic                    fault_found;
        logic [SENSOR_IDX_W-1:0] faulty_sensor;
        wsum_arr_t               sums;
    } win_result_t;

endpackage

// ===== rtl/core/msfd_stats.sv =====
module msfd_stats
    import msfd_pkg::*;
(
    input  sample_arr_t         samples,
    output logic [SUM_W-1:0]    cross_sum,
    output logic [SPREAD_W-1:0] spread_x16
);

    logic [SUM_W-1:0]     sum_w;
    logic [SUMSQ_W-1:0]   sumsq_w;
    logic [SUMSQ_W+1:0]   spread_full;

    always_comb
    begin
        sum_w   = '0;
        sumsq_w = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sum_w   = sum_w + SUM_W'(samples[i]);
            sumsq_w = sumsq_w + SUMSQ_W'(samples[i] * samples[i]);
        end
    end

    // Sixteen times the population variance, never negative
    assign spread_full = {sumsq_w, 2'b00} - (SUMSQ_W+2)'(sum_w * sum_w);
    assign cross_sum   = sum_w;
    assign spread_x16  = spread_full[SPREAD_W-1:0];

endmodule

// ===== rtl/core/msfd_window.sv =====
module msfd_window
    import msfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  sample_arr_t         samples,
    input  logic [SUM_W-1:0]    cross_sum,
    input  logic [SPREAD_W-1:0] spread_x16,
    input  logic [VTHR_W-1:0]   variance_threshold,
    input  logic [DTHR_W-1:0]   distance_threshold,
    output win_result_t         result
);

    wsum_arr_t              sums_reg;
    wsum_arr_t              sums_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;

    wsum_arr_t              sums_upd;
    logic                   last_item;
    logic                   var_ok;
    logic [DIST_W-1:0]      scaled_mean;
    logic [DIST_W-1:0]      dist_limit;
    logic [DIST_W-1:0]      scaled_w;
    logic [DIST_W-1:0]      sensor_dist [NUM_SENSORS];
    logic [DIST_W-1:0]      best;
    logic [SENSOR_IDX_W-1:0] best_idx;
    logic                   fault;

    always_comb
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sums_upd[i] = sums_reg[i] + WSUM_W'(samples[i]);
        end
    end

    // Anything at or past the final slot closes the window
    assign last_item   = (pos_reg >= POS_W'(WINDOW_LENGTH - 1));
    assign var_ok      = ({1'b0, spread_x16} >= {variance_threshold, 4'b0000});
    assign scaled_mean = DIST_W'(WINDOW_LENGTH) * DIST_W'(cross_sum);
    assign dist_limit  = DIST_W'(4 * WINDOW_LENGTH) * DIST_W'(distance_threshold);

    always_comb
    begin
        scaled_w = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            scaled_w       = DIST_W'({sums_upd[i], 2'b00});
            sensor_dist[i] = (scaled_w >= scaled_mean) ? (scaled_w - scaled_mean)
                                                       : (scaled_mean - scaled_w);
        end
    end

    // Strictly greater keeps the lower index on a tie
    always_comb
    begin
        best     = '0;
        best_idx = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (sensor_dist[i] > best)
            begin
                best     = sensor_dist[i];
                best_idx = SENSOR_IDX_W'(i);
            end
        end
    end

    assign fault = last_item && var_ok && (best > dist_limit);

    always_comb
    begin
        result.window_end    = last_item;
        result.fault_found   = fault;
        result.faulty_sensor = fault ? best_idx : '0;
        result.sums          = last_item ? sums_upd : '0;
    end

    always_comb
    begin
        sums_next = sums_reg;
        pos_next  = pos_reg;
        if (advance)
        begin
            if (last_item)
            begin
                sums_next = '0;
                pos_next  = '0;
            end
            else
            begin
                sums_next = sums_upd;
                pos_next  = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== rtl/core/multi_sensor_fault_detector_unit.sv =====
// Channel   Direction  Transaction
// --------  ---------  -------------------------------------------------------
// s_*       in         four 10-bit sensor samples
// m_*       out        cross sum, spread, window sums, fault verdict; tlast
//                      marks the item that closes a window
// cfg_*     in         threshold register write (index, data), always ready
//
// One item per cycle sustained while m_tready stays high. An input transaction
// passes through an input register, then one pass of stats and fault-test logic
// into the result register. The window accumulators update as an item moves
// from the input register into the result register.
// Reset clears both stage valids, the window sums and position, and loads
// the thresholds with their defaults. A stalled result holds; the input stage
// accepts while it is empty or the result register is free or being drained.
module multi_sensor_fault_detector_unit
    import msfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [9:0] sample_a, [19:10] sample_b, [29:20] sample_c, [39:30] sample_d
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [11:0] cross_sum, [33:12] spread_x16, [34] fault_found,
    // [36:35] faulty_sensor, [50:37] window_sum_a, [64:51] window_sum_b,
    // [78:65] window_sum_c, [92:79] window_sum_d, [95:93] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,    // window_end

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Threshold registers
    logic [VTHR_W-1:0]   vthr_reg;
    logic [VTHR_W-1:0]   vthr_next;
    logic [DTHR_W-1:0]   dthr_reg;
    logic [DTHR_W-1:0]   dthr_next;

    // Input stage
    logic                in_valid_reg;
    logic                in_valid_next;
    sample_arr_t         in_samples_reg;
    sample_arr_t         in_samples_next;

    // Result stage
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [SUM_W-1:0]    out_sum_next;
    logic [SPREAD_W-1:0] out_spread_reg;
    logic [SPREAD_W-1:0] out_spread_next;
    win_result_t         out_win_reg;
    win_result_t         out_win_next;

    logic                in_take;
    logic                out_free;
    logic                advance;
    logic [SUM_W-1:0]    cross_sum_w;
    logic [SPREAD_W-1:0] spread_w;
    win_result_t         win_w;

    assign cfg_ready = 1'b1;

    // The result register frees when empty or drained this cycle; the input
    // register moves forward whenever the result register frees.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    msfd_stats u_stats (
        .samples    (in_samples_reg),
        .cross_sum  (cross_sum_w),
        .spread_x16 (spread_w)
    );

    msfd_window u_window (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .samples            (in_samples_reg),
        .cross_sum          (cross_sum_w),
        .spread_x16         (spread_w),
        .variance_threshold (vthr_reg),
        .distance_threshold (dthr_reg),
        .result             (win_w)
    );

    // Register writes; data is cut to the register's width
    always_comb
    begin
        vthr_next = vthr_reg;
        dthr_next = dthr_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_VAR_THR:  vthr_next = cfg_data[VTHR_W-1:0];
                CFG_DIST_THR: dthr_next = cfg_data[DTHR_W-1:0];
                default:      vthr_next = vthr_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_samples_next = in_samples_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                in_samples_next[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;
        out_spread_next = out_spread_reg;
        out_win_next    = out_win_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_sum_next    = cross_sum_w;
            out_spread_next = spread_w;
            out_win_next    = win_w;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vthr_reg      <= VTHR_RESET;
            dthr_reg      <= DTHR_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vthr_reg      <= vthr_next;
            dthr_reg      <= dthr_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_samples_reg <= in_samples_next;
        out_sum_reg    <= out_sum_next;
        out_spread_reg <= out_spread_next;
        out_win_reg    <= out_win_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_win_reg.window_end;
    assign m_tdata  = {3'b000,
                       out_win_reg.sums[3],
                       out_win_reg.sums[2],
                       out_win_reg.sums[1],
                       out_win_reg.sums[0],
                       out_win_reg.faulty_sensor,
                       out_win_reg.fault_found,
                       out_spread_reg,
                       out_sum_reg};

    // Input side stalls only when both stages hold an item and output is blocked
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    // A fault can only be reported on the item that closes a window
    a_fault_needs_window_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[34]) |-> m_tlast)
        else $error("fault reported outside window end");

    // Window sums and sensor index read zero mid-window
    a_mid_window_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[95:35] == '0))
        else $error("window fields nonzero mid-window");

    // An item in the input register reaches the result register next cycle
    // whenever the result register was free
    a_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> out_valid_reg)
        else $error("item failed to advance into result register");

endmodule
